[rtl/core/nsc_pkg.sv]
// nsc_pkg: shared types and constants of the NMEA sentence checker.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package nsc_pkg;

  // Default number of address bytes after the start byte
  localparam int ADDRESS_LEN_DEF = 5;

  // Reset value of the maximum sentence length register
  localparam logic [7:0] MAX_LEN_RESET = 8'd82;

  // Characters with a framing role
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Bit positions in the sticky error flags
  localparam int FLAG_FORMAT = 0;
  localparam int FLAG_BADCH  = 1;
  localparam int FLAG_EMPTY  = 2;

  // Width of the packed result word on the output bus
  localparam int RESULT_W = 21;
  localparam int TDATA_W  = 24;

  // Per-byte character classification
  typedef struct packed {
    logic       is_start;
    logic       is_star;
    logic       is_cr;
    logic       is_lf;
    logic       is_comma;
    logic       allowed;
    logic       hex_ok;
    logic [3:0] hex_val;
  } char_class_t;

  // One result, last field in the lowest bit
  typedef struct packed {
    logic [7:0] computed_checksum;
    logic [7:0] field_count;
    logic       data_error;
    logic       checksum_error;
    logic       format_error;
    logic       corrupt;
    logic       sentence_valid;
  } result_t;

endpackage

[rtl/core/nsc_char_class.sv]
// nsc_char_class: classifies one received byte (start, delimiters,
// allowed set, hex digit value). Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_char_class import nsc_pkg::*; (
  input  logic [7:0]  char_byte,
  output char_class_t cls
);

  logic is_lower;
  logic is_upper;
  logic is_digit;
  logic is_hex_uc;
  logic is_hex_lc;

  // Range decodes
  assign is_lower  = (char_byte >= 8'h61) && (char_byte <= 8'h7A);
  assign is_upper  = (char_byte >= 8'h41) && (char_byte <= 8'h5A);
  assign is_digit  = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign is_hex_uc = (char_byte >= 8'h41) && (char_byte <= 8'h46);
  assign is_hex_lc = (char_byte >= 8'h61) && (char_byte <= 8'h66);

  // Class word
  always_comb begin
    cls.is_start = (char_byte == CH_DOLLAR) || (char_byte == CH_BANG);
    cls.is_star  = (char_byte == CH_STAR);
    cls.is_cr    = (char_byte == CH_CR);
    cls.is_lf    = (char_byte == CH_LF);
    cls.is_comma = (char_byte == CH_COMMA);
    cls.allowed  = is_lower || is_upper || is_digit || (char_byte == CH_DOT) ||
                   (char_byte == CH_COMMA) || (char_byte == CH_STAR) ||
                   (char_byte == CH_DOLLAR) || (char_byte == CH_BANG);
    cls.hex_ok   = is_digit || is_hex_uc || is_hex_lc;
    // letters: low nibble 1..6 maps to 10..15
    if (is_digit) begin
      cls.hex_val = char_byte[3:0];
    end else if (is_hex_uc || is_hex_lc) begin
      cls.hex_val = char_byte[3:0] + 4'd9;
    end else begin
      cls.hex_val = 4'd0;
    end
  end

endmodule

[rtl/core/nsc_frame.sv]
// nsc_frame: sentence framing state, running XOR, counters and result build.
// Depends on nsc_pkg and nsc_char_class.
`timescale 1ns / 1ps

module nsc_frame import nsc_pkg::*; #(
  parameter int ADDR_LEN = ADDRESS_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] char_byte,
  input  logic [7:0] max_len,
  output logic       emit,
  output result_t    res
);

  localparam int ACW = $clog2(ADDR_LEN + 1);
  localparam logic [ACW-1:0] ADDR_LAST = ACW'(ADDR_LEN);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_HEX1 = 3'd3;
  localparam logic [2:0] PH_HEX2 = 3'd4;
  localparam logic [2:0] PH_CR   = 3'd5;
  localparam logic [2:0] PH_LF   = 3'd6;

  char_class_t    cls;
  logic [2:0]     phase, phase_next;
  logic [7:0]     running_xor, running_xor_next;
  logic [ACW-1:0] address_count, address_count_next;
  logic [7:0]     length_count, length_count_next;
  logic [7:0]     comma_count, comma_count_next;
  logic [7:0]     received_sum, received_sum_next;
  logic [2:0]     error_flags, error_flags_next;
  logic           fmt, dat, cks;

  nsc_char_class u_class (
    .char_byte (char_byte),
    .cls       (cls)
  );

  // Next-state logic for one byte
  always_comb begin
    phase_next         = phase;
    running_xor_next   = running_xor;
    address_count_next = address_count;
    length_count_next  = length_count;
    comma_count_next   = comma_count;
    received_sum_next  = received_sum;
    error_flags_next   = error_flags;
    emit               = 1'b0;

    if (cls.is_start) begin
      // start byte restarts from any phase, no result
      phase_next         = PH_ADDR;
      running_xor_next   = 8'd0;
      address_count_next = '0;
      length_count_next  = 8'd1;
      comma_count_next   = 8'd0;
      received_sum_next  = 8'd0;
      error_flags_next   = 3'd0;
      error_flags_next[FLAG_EMPTY]  = 1'b1;
      error_flags_next[FLAG_FORMAT] = (max_len == 8'd0);
    end else if ((phase == PH_IDLE) || (phase > PH_LF)) begin
      phase_next = PH_IDLE;
    end else begin
      // length limit: saturate and flag
      if (length_count >= max_len) begin
        error_flags_next[FLAG_FORMAT] = 1'b1;
      end else begin
        length_count_next = length_count + 8'd1;
      end

      unique case (phase)
        PH_ADDR: begin
          running_xor_next   = running_xor ^ char_byte;
          address_count_next = address_count + ACW'(1);
          if (address_count_next == ADDR_LAST) begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          if (cls.is_star) begin
            phase_next = PH_HEX1;
          end else begin
            running_xor_next = running_xor ^ char_byte;
            error_flags_next[FLAG_EMPTY] = 1'b0;
            if (!cls.allowed) begin
              error_flags_next[FLAG_BADCH] = 1'b1;
            end
            if (cls.is_comma && (comma_count != 8'hFF)) begin
              comma_count_next = comma_count + 8'd1;
            end
          end
        end
        PH_HEX1, PH_HEX2: begin
          // bad digit counts as zero and flags format
          if (!cls.hex_ok) begin
            error_flags_next[FLAG_FORMAT] = 1'b1;
          end
          received_sum_next = {received_sum[3:0], cls.hex_val};
          phase_next = (phase == PH_HEX1) ? PH_HEX2 : PH_CR;
        end
        PH_CR: begin
          if (cls.is_cr) begin
            phase_next = PH_LF;
          end else begin
            error_flags_next[FLAG_FORMAT] = 1'b1;
            emit       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          // LF phase: result either way
          if (!cls.is_lf) begin
            error_flags_next[FLAG_FORMAT] = 1'b1;
          end
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Result word from the updated state
  assign fmt = error_flags_next[FLAG_FORMAT];
  assign dat = error_flags_next[FLAG_BADCH] | error_flags_next[FLAG_EMPTY];
  assign cks = (received_sum_next != running_xor_next);

  always_comb begin
    res.sentence_valid    = ~(fmt | dat | cks);
    res.corrupt           = fmt | cks;
    res.format_error      = fmt;
    res.checksum_error    = cks;
    res.data_error        = dat;
    res.field_count       = comma_count_next;
    res.computed_checksum = running_xor_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      running_xor   <= 8'd0;
      address_count <= '0;
      length_count  <= 8'd0;
      comma_count   <= 8'd0;
      received_sum  <= 8'd0;
      error_flags   <= 3'd0;
    end else if (fire) begin
      phase         <= phase_next;
      running_xor   <= running_xor_next;
      address_count <= address_count_next;
      length_count  <= length_count_next;
      comma_count   <= comma_count_next;
      received_sum  <= received_sum_next;
      error_flags   <= error_flags_next;
    end
  end

endmodule

[rtl/core/nsc_out_queue.sv]
// nsc_out_queue: two-entry result queue that registers the output word and
// decouples the stream sides. Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_out_queue import nsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam logic [1:0] DEPTH = 2'd2;

  result_t    q [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == DEPTH);
  assign pop       = out_valid && out_ready;
  assign out_data  = q[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_data;
  end

endmodule

[rtl/core/nmea_sentence_checker_top.sv]
// Channel | Dir | Signals                        | Word
// in      | in  | s_tvalid s_tready s_tdata[7:0] | char_byte
// out     | out | m_tvalid m_tready m_tdata[23:0]| one sentence result
// cfg     | in  | cfg_we cfg_wdata[7:0]          | max_sentence_length
//
// One byte per cycle while the output queue is not full: input register, then
// framing logic that writes the result into a two-entry output queue.
// The byte is held in the input register and its result in the output queue.
// Reset (rst, synchronous) clears framing state, empties the queue and sets
// max_sentence_length to 82.
// s_tready drops only while the byte register is full and the output queue
// holds two unread results.
// Depends on nsc_pkg, nsc_frame, nsc_out_queue.
`timescale 1ns / 1ps

module nmea_sentence_checker_top import nsc_pkg::*; #(
  parameter int ADDR_LEN = ADDRESS_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] char_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  // [0] sentence_valid, [1] corrupt, [2] format_error, [3] checksum_error,
  // [4] data_error, [12:5] field_count, [20:13] computed_checksum, rest zero
  output logic [TDATA_W-1:0] m_tdata,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic [7:0] max_len;
  logic       q_full;
  logic       fire;
  logic       emit;
  result_t    res;
  result_t    out_res;

  assign fire     = in_valid && !q_full;
  assign s_tready = !in_valid || !q_full;

  // Input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  nsc_frame #(
    .ADDR_LEN (ADDR_LEN)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_byte (in_byte),
    .max_len   (max_len),
    .emit      (emit),
    .res       (res)
  );

  nsc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && emit),
    .push_data (res),
    .full      (q_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {(TDATA_W - RESULT_W)'(0), out_res};

endmodule

[rtl/core/nsc_checker.sv]
// nsc_checker: port-level assertions for the NMEA sentence checker, bound
// to nmea_sentence_checker_top. Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_checker import nsc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  // Output queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Valid flag is the inverse of the three error flags
  a_valid_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == !(m_tdata[2] || m_tdata[3] || m_tdata[4])))
    else $error("sentence_valid disagrees with error flags");

  // Corrupt is format or checksum error
  a_corrupt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1] == (m_tdata[2] || m_tdata[3])))
    else $error("corrupt disagrees with format/checksum flags");

  // A result from an empty queue follows an accepted input byte
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a byte accepted two cycles earlier");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind nmea_sentence_checker_top nsc_checker u_nsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
